[sv/tcw_pkg.sv]
// tcw_pkg: operation codes, control character codes and cell constants
// for the text console writer. No dependencies.
`default_nettype none

package tcw_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_MOVE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;

    localparam logic [7:0]  BLANK_CHAR  = 8'h20;
    localparam logic [7:0]  ATTR_RESET  = 8'h0F;
    localparam logic [15:0] RESET_CELL  = 16'h0F20;

    // cell write request from the cursor unit
    typedef struct packed {
        logic wr_en;
        logic wr_blank;
        logic scroll;
    } wr_ctl_t;

endpackage

`default_nettype wire

[sv/tcw_cell_ram.sv]
// tcw_cell_ram: single-port-write, single-port-read cell store with
// registered read data. No dependencies.
`default_nettype none

module tcw_cell_ram #(
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [15:0]   wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [15:0]   rdata
);

    logic [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/tcw_cursor.sv]
// tcw_cursor: next cursor position and cell write request for a
// write-character request. Depends on tcw_pkg.
`default_nettype none

module tcw_cursor #(
    parameter int COLUMNS = 80,
    parameter int ROWS = 25,
    localparam int CW = $clog2(COLUMNS),
    localparam int RW = $clog2(ROWS)
) (
    input  wire logic [CW-1:0] col,
    input  wire logic [RW-1:0] row,
    input  wire logic [7:0]    character,
    output logic      [CW-1:0] next_col,
    output logic      [RW-1:0] next_row,
    output logic      [CW-1:0] wr_col,
    output tcw_pkg::wr_ctl_t   ctl
);

    logic [CW:0] c_ext;
    logic [RW:0] r_ext;
    logic [CW:0] tab_sum;

    always_comb
    begin
        c_ext   = {1'b0, col};
        r_ext   = {1'b0, row};
        tab_sum = {1'b0, col} + (CW+1)'(4);
        wr_col  = col;
        ctl     = '0;
        case (character)
            tcw_pkg::CH_NEWLINE:
            begin
                c_ext = '0;
                r_ext = r_ext + (RW+1)'(1);
            end
            tcw_pkg::CH_RETURN:
            begin
                c_ext = '0;
            end
            tcw_pkg::CH_TAB:
            begin
                c_ext = {tab_sum[CW:2], 2'b00};
            end
            tcw_pkg::CH_BACKSPACE:
            begin
                if (col != '0)
                begin
                    c_ext        = {1'b0, col - CW'(1)};
                    wr_col       = col - CW'(1);
                    ctl.wr_en    = 1'b1;
                    ctl.wr_blank = 1'b1;
                end
            end
            default:
            begin
                c_ext     = {1'b0, col} + (CW+1)'(1);
                ctl.wr_en = 1'b1;
            end
        endcase
        if (c_ext >= (CW+1)'(COLUMNS))
        begin
            c_ext = '0;
            r_ext = r_ext + (RW+1)'(1);
        end
        if (r_ext >= (RW+1)'(ROWS))
        begin
            r_ext      = (RW+1)'(ROWS - 1);
            ctl.scroll = 1'b1;
        end
        next_col = c_ext[CW-1:0];
        next_row = r_ext[RW-1:0];
    end

endmodule

`default_nettype wire

[sv/text_console_writer.sv]
// text_console_writer: text-mode screen engine, cell store plus cursor.
// Depends on tcw_pkg, tcw_cell_ram, tcw_cursor.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid in_ready op character column row | request in
//  out     | out_valid out_ready cursor_position cell_data scrolled | result out
//  cfg     | cfg_valid cfg_ready cfg_data          | attribute write
//
// Write without scroll, move: IDLE, EXEC, PUSH; read: IDLE, EXEC, READ, PUSH
// (registered RAM read). Scroll copies all rows but the top one up a row,
// then blanks the last row; clear blanks every cell. All are paced by the
// single RAM write port, one cell per cycle. After reset a clearing pass
// over every cell runs with in_ready low. A waiting result holds in the
// output register; the next request is taken meanwhile.
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS = 25
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [7:0]  character,
    input  wire logic [7:0]  column,
    input  wire logic [7:0]  row,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [10:0]      cursor_position,
    output logic [15:0]      cell_data,
    output logic             scrolled,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int MOVE  = CELLS - COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CNTW  = $clog2(CELLS + 1);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_SCROLL = 3'd4;
    localparam logic [2:0] S_FILL   = 3'd5;
    localparam logic [2:0] S_PUSH   = 3'd6;

    logic [2:0]      state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            mv_valid_reg, mv_valid_next;
    logic [AW-1:0]   mv_addr_reg, mv_addr_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [7:0]      attr_reg, attr_next;
    logic            out_valid_reg, out_valid_next;

    logic [1:0]      op_reg, op_next;
    logic [7:0]      char_reg, char_next;
    logic [CW-1:0]   tcol_reg, tcol_next;
    logic [RW-1:0]   trow_reg, trow_next;
    logic            scr_reg, scr_next;
    logic [15:0]     cell_reg, cell_next;
    logic [15:0]     fill_reg, fill_next;
    logic [10:0]     pos_reg, pos_next;
    logic [15:0]     data_reg, data_next;
    logic            sflag_reg, sflag_next;

    logic [RW-1:0]   mul_row;
    logic [CW-1:0]   mul_col;
    logic [AW-1:0]   lin;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [15:0]     ram_wdata, ram_rdata;

    logic [CW-1:0]   cur_next_col, cur_wr_col;
    logic [RW-1:0]   cur_next_row;
    tcw_pkg::wr_ctl_t cur_ctl;

    logic            in_fire, push_ok;
    logic [CW-1:0]   col_clamp;
    logic [RW-1:0]   row_clamp;

    tcw_cell_ram #(
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tcw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .col       (col_reg),
        .row       (row_reg),
        .character (char_reg),
        .next_col  (cur_next_col),
        .next_row  (cur_next_row),
        .wr_col    (cur_wr_col),
        .ctl       (cur_ctl)
    );

    assign in_ready        = (state_reg == S_IDLE);
    assign in_fire         = in_valid && in_ready;
    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign cursor_position = pos_reg;
    assign cell_data       = data_reg;
    assign scrolled        = sflag_reg;
    assign push_ok         = !out_valid_reg || out_ready;

    assign col_clamp = (column >= 8'(COLUMNS)) ? CW'(COLUMNS - 1) : column[CW-1:0];
    assign row_clamp = (row >= 8'(ROWS)) ? RW'(ROWS - 1) : row[RW-1:0];

    // shared linear address: read target, write target, or cursor
    always_comb
    begin
        if (state_reg == S_EXEC && op_reg == tcw_pkg::OP_READ)
        begin
            mul_row = trow_reg;
            mul_col = tcol_reg;
        end
        else if (state_reg == S_EXEC)
        begin
            mul_row = row_reg;
            mul_col = cur_wr_col;
        end
        else
        begin
            mul_row = row_reg;
            mul_col = col_reg;
        end
        lin = AW'(mul_row) * AW'(COLUMNS) + AW'(mul_col);
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mv_valid_next  = 1'b0;
        mv_addr_next   = cnt_reg[AW-1:0];
        col_next       = col_reg;
        row_next       = row_reg;
        attr_next      = cfg_valid ? cfg_data : attr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        op_next        = op_reg;
        char_next      = char_reg;
        tcol_next      = tcol_reg;
        trow_next      = trow_reg;
        scr_next       = scr_reg;
        cell_next      = cell_reg;
        fill_next      = fill_reg;
        pos_next       = pos_reg;
        data_next      = data_reg;
        sflag_next     = sflag_reg;
        ram_we         = 1'b0;
        ram_waddr      = lin;
        ram_wdata      = fill_reg;
        ram_re         = 1'b0;
        ram_raddr      = lin;

        case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[AW-1:0];
                ram_wdata = tcw_pkg::RESET_CELL;
                cnt_next  = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next    = op;
                    char_next  = character;
                    tcol_next  = col_clamp;
                    trow_next  = row_clamp;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                scr_next  = 1'b0;
                cell_next = '0;
                case (op_reg)
                    tcw_pkg::OP_WRITE:
                    begin
                        ram_we    = cur_ctl.wr_en;
                        ram_wdata = {attr_reg,
                                     cur_ctl.wr_blank ? tcw_pkg::BLANK_CHAR : char_reg};
                        col_next  = cur_next_col;
                        row_next  = cur_next_row;
                        scr_next  = cur_ctl.scroll;
                        if (cur_ctl.scroll)
                        begin
                            cnt_next   = '0;
                            state_next = S_SCROLL;
                        end
                        else
                        begin
                            state_next = S_PUSH;
                        end
                    end
                    tcw_pkg::OP_MOVE:
                    begin
                        col_next   = tcol_reg;
                        row_next   = trow_reg;
                        state_next = S_PUSH;
                    end
                    tcw_pkg::OP_CLEAR:
                    begin
                        col_next   = '0;
                        row_next   = '0;
                        cnt_next   = '0;
                        fill_next  = {attr_reg, tcw_pkg::BLANK_CHAR};
                        state_next = S_FILL;
                    end
                    default:
                    begin
                        ram_re     = 1'b1;
                        state_next = S_READ;
                    end
                endcase
            end
            S_READ:
            begin
                cell_next  = ram_rdata;
                state_next = S_PUSH;
            end
            S_SCROLL:
            begin
                // read row below, write it back one row up in the next cycle
                if (cnt_reg < CNTW'(MOVE))
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = cnt_reg[AW-1:0] + AW'(COLUMNS);
                    mv_valid_next = 1'b1;
                    cnt_next      = cnt_reg + CNTW'(1);
                end
                else
                begin
                    fill_next  = {attr_reg, tcw_pkg::BLANK_CHAR};
                    state_next = S_FILL;
                end
                if (mv_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = mv_addr_reg;
                    ram_wdata = ram_rdata;
                end
            end
            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[AW-1:0];
                ram_wdata = fill_reg;
                cnt_next  = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(CELLS - 1))
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (push_ok)
                begin
                    pos_next       = 11'(lin);
                    data_next      = cell_reg;
                    sflag_next     = scr_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            mv_valid_reg  <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            attr_reg      <= tcw_pkg::ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            mv_valid_reg  <= mv_valid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            attr_reg      <= attr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mv_addr_reg <= mv_addr_next;
        op_reg      <= op_next;
        char_reg    <= char_next;
        tcol_reg    <= tcol_next;
        trow_reg    <= trow_next;
        scr_reg     <= scr_next;
        cell_reg    <= cell_next;
        fill_reg    <= fill_next;
        pos_reg     <= pos_next;
        data_reg    <= data_next;
        sflag_reg   <= sflag_next;
    end

endmodule

`default_nettype wire

[sv/tcw_checker.sv]
// tcw_checker: port-level assertions for text_console_writer, bound to
// the top level below. Depends on text_console_writer ports only.
`default_nettype none

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS = 25
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [10:0] cursor_position,
    input wire logic [15:0] cell_data,
    input wire logic        scrolled
);

    localparam logic        CHECK_POS = (ROWS * COLUMNS <= 2048);
    localparam logic [11:0] CELLS12   = 12'(ROWS * COLUMNS);
    localparam logic [11:0] LAST_ROW  = 12'((ROWS - 1) * COLUMNS);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cursor_position)
            && $stable(cell_data) && $stable(scrolled))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in progress");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !CHECK_POS || ({1'b0, cursor_position} < CELLS12))
        else $error("cursor outside screen");

    a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scrolled |-> !CHECK_POS || ({1'b0, cursor_position} >= LAST_ROW))
        else $error("scroll left cursor above last row");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cursor_position (cursor_position),
    .cell_data       (cell_data),
    .scrolled        (scrolled)
);

`default_nettype wire

[tb/text_console_writer_test.sv]
// text_console_writer_test: self-checking bench for the text console writer.
// Holds its own screen, cursor and attribute copy to predict every reply.
// Depends on tcw_pkg and text_console_writer.
`default_nettype none

module text_console_writer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS = 80;
    localparam int LINES = 25;
    localparam int CELLS = COLS * LINES;
    localparam int ITEMS_PER_PHASE = 144;
    localparam int PHASES = 8;
    // idle gap between phases; clear and scroll finish walking the store before their reply
    localparam int SETTLE_CYCLES = CELLS + 100;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] ch;
        logic [7:0] col;
        logic [7:0] line;
    } console_cmd_t;

    typedef struct packed {
        logic [10:0] position;
        logic [15:0] cell_word;
        logic        scrolled;
    } console_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  op = tcw_pkg::OP_WRITE;
    logic [7:0]  character = '0;
    logic [7:0]  column = '0;
    logic [7:0]  row = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [10:0] cursor_position;
    logic [15:0] cell_data;
    logic        scrolled;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    console_cmd_t   queued_commands[$];
    console_reply_t predicted_replies[$];
    int unsigned    queued_total = 0;
    int unsigned    fail_count = 0;
    int unsigned    send_idle_pct = 0;
    int unsigned    recv_stall_pct = 0;

    // screen image and cursor as the block should hold them
    logic [15:0] screen_image[CELLS];
    int unsigned cur_col;
    int unsigned cur_line;
    logic [7:0]  attr_now;

    text_console_writer #(
        .COLUMNS(COLS),
        .ROWS(LINES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .character(character),
        .column(column),
        .row(row),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cursor_position(cursor_position),
        .cell_data(cell_data),
        .scrolled(scrolled),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned clamp_to(logic [7:0] v, int unsigned lim);
        return (v >= lim) ? lim - 1 : int'(v);
    endfunction

    function automatic console_reply_t console_apply(console_cmd_t c);
        console_reply_t rep;
        int unsigned    rc;
        int unsigned    rl;
        rep = '0;
        case (c.op)
            tcw_pkg::OP_WRITE:
            begin
                case (c.ch)
                    tcw_pkg::CH_NEWLINE:
                    begin
                        cur_col = 0;
                        cur_line++;
                    end
                    tcw_pkg::CH_RETURN: cur_col = 0;
                    tcw_pkg::CH_TAB: cur_col = (cur_col + 4) & ~32'd3;
                    tcw_pkg::CH_BACKSPACE:
                    begin
                        if (cur_col > 0)
                        begin
                            cur_col--;
                            screen_image[cur_line * COLS + cur_col] =
                                {attr_now, tcw_pkg::BLANK_CHAR};
                        end
                    end
                    default:
                    begin
                        screen_image[cur_line * COLS + cur_col] = {attr_now, c.ch};
                        cur_col++;
                    end
                endcase
                if (cur_col >= COLS)
                begin
                    cur_col = 0;
                    cur_line++;
                end
                if (cur_line >= LINES)
                begin
                    for (int i = 0; i < CELLS - COLS; i++)
                        screen_image[i] = screen_image[i + COLS];
                    for (int i = CELLS - COLS; i < CELLS; i++)
                        screen_image[i] = {attr_now, tcw_pkg::BLANK_CHAR};
                    cur_line = LINES - 1;
                    rep.scrolled = 1'b1;
                end
            end
            tcw_pkg::OP_MOVE:
            begin
                cur_col = clamp_to(c.col, COLS);
                cur_line = clamp_to(c.line, LINES);
            end
            tcw_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen_image[i] = {attr_now, tcw_pkg::BLANK_CHAR};
                cur_col = 0;
                cur_line = 0;
            end
            default:
            begin
                rc = clamp_to(c.col, COLS);
                rl = clamp_to(c.line, LINES);
                rep.cell_word = screen_image[rl * COLS + rc];
            end
        endcase
        rep.position = 11'(cur_line * COLS + cur_col);
        return rep;
    endfunction

    // request driver
    always @(posedge clk)
    begin : drive
        console_cmd_t next_cmd;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                predicted_replies.push_back(console_apply('{op, character, column, row}));
            if (!in_valid || in_ready)
            begin
                if (queued_commands.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_cmd = queued_commands.pop_front();
                    op <= next_cmd.op;
                    character <= next_cmd.ch;
                    column <= next_cmd.col;
                    row <= next_cmd.line;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // reply monitor
    always @(posedge clk)
    begin : watch
        console_reply_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_replies.size() == 0)
                begin
                    $error("reply with no request pending: cursor_position %0d", cursor_position);
                    fail_count++;
                end
                else
                begin
                    want = predicted_replies.pop_front();
                    if (cursor_position !== want.position)
                    begin
                        $error("cursor_position: expected %0d, got %0d",
                               want.position, cursor_position);
                        fail_count++;
                    end
                    if (cell_data !== want.cell_word)
                    begin
                        $error("cell_data: expected %04h, got %04h", want.cell_word, cell_data);
                        fail_count++;
                    end
                    if (scrolled !== want.scrolled)
                    begin
                        $error("scrolled: expected %0b, got %0b", want.scrolled, scrolled);
                        fail_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic add_cmd(logic [1:0] o, logic [7:0] ch, logic [7:0] col, logic [7:0] line);
        queued_commands.push_back('{o, ch, col, line});
        queued_total++;
    endtask

    function automatic logic [7:0] pick_char();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 70)
            return 8'($urandom_range(126, 32));
        else if (k < 76)
            return tcw_pkg::CH_NEWLINE;
        else if (k < 80)
            return tcw_pkg::CH_RETURN;
        else if (k < 86)
            return tcw_pkg::CH_TAB;
        else if (k < 92)
            return tcw_pkg::CH_BACKSPACE;
        return 8'($urandom_range(255));
    endfunction

    task automatic add_random_burst();
        int unsigned kind;
        logic [7:0]  c0;
        logic [7:0]  r0;
        kind = $urandom_range(99);
        if (kind < 60)
        begin
            // place the cursor, type a short string, read part of it back
            c0 = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(COLS - 1));
            r0 = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(LINES - 1));
            add_cmd(tcw_pkg::OP_MOVE, 8'($urandom_range(255)), c0, r0);
            repeat ($urandom_range(12, 1))
                add_cmd(tcw_pkg::OP_WRITE, pick_char(), 8'($urandom_range(255)),
                        8'($urandom_range(255)));
            repeat ($urandom_range(3, 1))
                add_cmd(tcw_pkg::OP_READ, 8'($urandom_range(255)), 8'(c0 + $urandom_range(12)),
                        8'(r0 + $urandom_range(1)));
        end
        else if (kind < 80)
        begin
            repeat ($urandom_range(16, 4))
                add_cmd(tcw_pkg::OP_WRITE, pick_char(), 8'($urandom_range(255)),
                        8'($urandom_range(255)));
        end
        else if (kind < 90)
        begin
            repeat (3)
                add_cmd($urandom_range(1) ? tcw_pkg::OP_MOVE : tcw_pkg::OP_READ,
                        8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)));
        end
        else if (kind < 98)
        begin
            repeat (2)
            begin
                case ($urandom_range(2))
                    0: add_cmd(tcw_pkg::OP_WRITE, 8'($urandom_range(255)),
                               8'($urandom_range(255)), 8'($urandom_range(255)));
                    1: add_cmd(tcw_pkg::OP_MOVE, 8'($urandom_range(255)),
                               8'($urandom_range(255)), 8'($urandom_range(255)));
                    default: add_cmd(tcw_pkg::OP_READ, 8'($urandom_range(255)),
                                     8'($urandom_range(255)), 8'($urandom_range(255)));
                endcase
            end
        end
        else
        begin
            add_cmd(tcw_pkg::OP_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)));
            repeat ($urandom_range(4, 1))
                add_cmd(tcw_pkg::OP_WRITE, pick_char(), 8'($urandom_range(255)),
                        8'($urandom_range(255)));
        end
    endtask

    task automatic wait_drained();
        while (queued_commands.size() != 0 || in_valid || predicted_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_attribute(logic [7:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        attr_now = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idle_mode(int unsigned mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
        endcase
    endtask

    initial
    begin : stimulus
        int unsigned target;
        for (int i = 0; i < CELLS; i++)
            screen_image[i] = tcw_pkg::RESET_CELL;
        cur_col = 0;
        cur_line = 0;
        attr_now = tcw_pkg::ATTR_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset contents, controls, clamping, wrap, scroll, clear
        add_cmd(tcw_pkg::OP_READ, 8'h00, 8'd0, 8'd0);
        add_cmd(tcw_pkg::OP_WRITE, 8'h41, 8'd0, 8'd0);
        add_cmd(tcw_pkg::OP_WRITE, 8'h00, 8'd0, 8'd0);
        add_cmd(tcw_pkg::OP_WRITE, 8'hFF, 8'd0, 8'd0);
        add_cmd(tcw_pkg::OP_WRITE, tcw_pkg::CH_BACKSPACE, 8'd0, 8'd0);
        add_cmd(tcw_pkg::OP_READ, 8'h00, 8'd2, 8'd0);
        add_cmd(tcw_pkg::OP_READ, 8'h00, 8'd1, 8'd0);
        add_cmd(tcw_pkg::OP_WRITE, tcw_pkg::CH_RETURN, 8'd0, 8'd0);
        add_cmd(tcw_pkg::OP_WRITE, tcw_pkg::CH_BACKSPACE, 8'd0, 8'd0);
        add_cmd(tcw_pkg::OP_WRITE, tcw_pkg::CH_TAB, 8'd0, 8'd0);
        add_cmd(tcw_pkg::OP_WRITE, tcw_pkg::CH_TAB, 8'd0, 8'd0);
        add_cmd(tcw_pkg::OP_MOVE, 8'h00, 8'd255, 8'd255);
        add_cmd(tcw_pkg::OP_WRITE, 8'h5A, 8'd0, 8'd0);
        add_cmd(tcw_pkg::OP_READ, 8'h00, 8'd79, 8'd23);
        add_cmd(tcw_pkg::OP_MOVE, 8'h00, 8'd77, 8'd3);
        add_cmd(tcw_pkg::OP_WRITE, tcw_pkg::CH_TAB, 8'd0, 8'd0);
        add_cmd(tcw_pkg::OP_MOVE, 8'h00, 8'd0, 8'd24);
        add_cmd(tcw_pkg::OP_WRITE, tcw_pkg::CH_NEWLINE, 8'd0, 8'd0);
        add_cmd(tcw_pkg::OP_READ, 8'h00, 8'd0, 8'd0);
        add_cmd(tcw_pkg::OP_MOVE, 8'h00, 8'd255, 8'd0);
        add_cmd(tcw_pkg::OP_WRITE, 8'h78, 8'd0, 8'd0);
        add_cmd(tcw_pkg::OP_CLEAR, 8'hFF, 8'd255, 8'd255);
        add_cmd(tcw_pkg::OP_READ, 8'h00, 8'd255, 8'd255);
        add_cmd(tcw_pkg::OP_READ, 8'h00, 8'd0, 8'd0);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            repeat (SETTLE_CYCLES) @(posedge clk);
            if (p == 0)
                write_attribute(8'h00);
            else if (p == 1)
                write_attribute(8'hFF);
            else
                write_attribute(8'($urandom_range(255)));
            set_idle_mode(p % 4);
            target = queued_total + ITEMS_PER_PHASE;
            while (queued_total < target)
                add_random_burst();
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && predicted_replies.size() == 0)
            $display("text_console_writer_test OK");
        else
            $display("text_console_writer_test NOT OK");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("text_console_writer_test NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
sv/tcw_pkg.sv
sv/tcw_cell_ram.sv
sv/tcw_cursor.sv
sv/text_console_writer.sv
sv/tcw_checker.sv
tb/text_console_writer_test.sv
